// ===== hw/rtl/via_pkg.sv =====
// Package for the versatile interface adapter: item and result types,
// action codes, register addresses, flag masks and control bit positions.
// Has no dependencies of its own.
`default_nettype none

package via_pkg;

    // Action codes carried by each input item.
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_TICK  = 3'd2;
    localparam logic [2:0] ACT_CA1   = 3'd3;
    localparam logic [2:0] ACT_CB1   = 3'd4;

    // Register addresses.
    localparam logic [3:0] REG_ORB    = 4'h0;
    localparam logic [3:0] REG_ORA    = 4'h1;
    localparam logic [3:0] REG_DDRB   = 4'h2;
    localparam logic [3:0] REG_DDRA   = 4'h3;
    localparam logic [3:0] REG_T1CL   = 4'h4;
    localparam logic [3:0] REG_T1CH   = 4'h5;
    localparam logic [3:0] REG_T1LL   = 4'h6;
    localparam logic [3:0] REG_T1LH   = 4'h7;
    localparam logic [3:0] REG_T2CL   = 4'h8;
    localparam logic [3:0] REG_T2CH   = 4'h9;
    localparam logic [3:0] REG_SR     = 4'hA;
    localparam logic [3:0] REG_ACR    = 4'hB;
    localparam logic [3:0] REG_PCR    = 4'hC;
    localparam logic [3:0] REG_IFR    = 4'hD;
    localparam logic [3:0] REG_IER    = 4'hE;
    localparam logic [3:0] REG_ORA_NH = 4'hF;

    // Interrupt flag masks.
    localparam logic [6:0] IFR_CA2 = 7'h01;
    localparam logic [6:0] IFR_CA1 = 7'h02;
    localparam logic [6:0] IFR_SR  = 7'h04;
    localparam logic [6:0] IFR_CB2 = 7'h08;
    localparam logic [6:0] IFR_CB1 = 7'h10;
    localparam logic [6:0] IFR_T2  = 7'h20;
    localparam logic [6:0] IFR_T1  = 7'h40;

    // Control register bit positions.
    localparam int ACR_PB7_OUT  = 7;
    localparam int ACR_T1_FREE  = 6;
    localparam int ACR_T2_PULSE = 5;
    localparam int PCR_CA1_POS  = 0;
    localparam int PCR_CB1_POS  = 4;
    localparam int IER_SET      = 7;

    localparam logic [15:0] TIMER_IDLE = 16'hFFFF;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       pin_level;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
    } via_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_out;
        logic [7:0] port_a_dir;
        logic [7:0] port_b_out;
        logic [7:0] port_b_dir;
    } via_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/via_if.sv =====
// Handshake interfaces for the adapter's item and result channels.
// Payload widths follow the field definitions; no package dependency.
`default_nettype none

interface via_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic       pin_level;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;

    modport source (output valid, action, reg_addr, write_data, pin_level,
                    port_a_pins, port_b_pins, input ready);
    modport sink   (input valid, action, reg_addr, write_data, pin_level,
                    port_a_pins, port_b_pins, output ready);
endinterface

interface via_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_a_dir;
    logic [7:0] port_b_out;
    logic [7:0] port_b_dir;

    modport source (output valid, read_data, irq, port_a_out, port_a_dir,
                    port_b_out, port_b_dir, input ready);
    modport sink   (input valid, read_data, irq, port_a_out, port_a_dir,
                    port_b_out, port_b_dir, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/via_core.sv =====
// Register file, timers and interrupt logic of the adapter. Applies one item
// per fire cycle and presents the result combinationally. Uses via_pkg.
`default_nettype none

module via_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 fire,
    input  via_pkg::via_item_t  item,
    output via_pkg::via_result_t result
);
    import via_pkg::*;

    logic [7:0]  out_reg_b_reg, out_reg_b_next;
    logic [7:0]  out_reg_a_reg, out_reg_a_next;
    logic [7:0]  dir_mask_b_reg, dir_mask_b_next;
    logic [7:0]  dir_mask_a_reg, dir_mask_a_next;
    logic [15:0] timer1_count_reg, timer1_count_next;
    logic [15:0] timer1_reload_reg, timer1_reload_next;
    logic [15:0] timer2_count_reg, timer2_count_next;
    logic [7:0]  timer2_low_hold_reg, timer2_low_hold_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  aux_control_reg, aux_control_next;
    logic [7:0]  periph_control_reg, periph_control_next;
    logic [6:0]  irq_flags_reg, irq_flags_next;
    logic [6:0]  irq_enables_reg, irq_enables_next;
    logic        timer1_active_reg, timer1_active_next;
    logic        timer2_active_reg, timer2_active_next;
    logic        ca1_last_reg, ca1_last_next;
    logic        cb1_last_reg, cb1_last_next;

    logic [7:0] read_byte;
    logic [6:0] flag_clr;
    logic [6:0] flag_set;
    logic [7:0] port_a_value;
    logic [7:0] port_b_value;
    logic       irq_now;
    logic [15:0] reload_hi_written;

    always_comb
    begin
        port_a_value = (out_reg_a_reg & dir_mask_a_reg)
                     | (item.port_a_pins & ~dir_mask_a_reg);
        port_b_value = (out_reg_b_reg & dir_mask_b_reg)
                     | (item.port_b_pins & ~dir_mask_b_reg);
        // With PB7 output enabled, timer 1 owns that bit.
        if (aux_control_reg[ACR_PB7_OUT])
        begin
            port_b_value[7] = out_reg_b_reg[7];
        end
    end

    assign irq_now = |(irq_flags_reg & irq_enables_reg);
    assign reload_hi_written = {item.write_data, timer1_reload_reg[7:0]};

    always_comb
    begin
        out_reg_b_next       = out_reg_b_reg;
        out_reg_a_next       = out_reg_a_reg;
        dir_mask_b_next      = dir_mask_b_reg;
        dir_mask_a_next      = dir_mask_a_reg;
        timer1_count_next    = timer1_count_reg;
        timer1_reload_next   = timer1_reload_reg;
        timer2_count_next    = timer2_count_reg;
        timer2_low_hold_next = timer2_low_hold_reg;
        shift_byte_next      = shift_byte_reg;
        aux_control_next     = aux_control_reg;
        periph_control_next  = periph_control_reg;
        irq_enables_next     = irq_enables_reg;
        timer1_active_next   = timer1_active_reg;
        timer2_active_next   = timer2_active_reg;
        ca1_last_next        = ca1_last_reg;
        cb1_last_next        = cb1_last_reg;
        read_byte            = '0;
        flag_clr             = '0;
        flag_set             = '0;

        if (fire)
        begin
            unique case (item.action)
                ACT_READ:
                begin
                    unique case (item.reg_addr)
                        REG_ORB:
                        begin
                            flag_clr  = IFR_CB1 | IFR_CB2;
                            read_byte = port_b_value;
                        end
                        REG_ORA:
                        begin
                            flag_clr  = IFR_CA1 | IFR_CA2;
                            read_byte = port_a_value;
                        end
                        REG_DDRB: read_byte = dir_mask_b_reg;
                        REG_DDRA: read_byte = dir_mask_a_reg;
                        REG_T1CL:
                        begin
                            flag_clr  = IFR_T1;
                            read_byte = timer1_count_reg[7:0];
                        end
                        REG_T1CH: read_byte = timer1_count_reg[15:8];
                        REG_T1LL: read_byte = timer1_reload_reg[7:0];
                        REG_T1LH: read_byte = timer1_reload_reg[15:8];
                        REG_T2CL:
                        begin
                            flag_clr  = IFR_T2;
                            read_byte = timer2_count_reg[7:0];
                        end
                        REG_T2CH: read_byte = timer2_count_reg[15:8];
                        REG_SR:
                        begin
                            flag_clr  = IFR_SR;
                            read_byte = shift_byte_reg;
                        end
                        REG_ACR:  read_byte = aux_control_reg;
                        REG_PCR:  read_byte = periph_control_reg;
                        REG_IFR:  read_byte = {irq_now, irq_flags_reg};
                        REG_IER:  read_byte = {1'b1, irq_enables_reg};
                        default:  read_byte = port_a_value;
                    endcase
                end
                ACT_WRITE:
                begin
                    unique case (item.reg_addr)
                        REG_ORB:
                        begin
                            out_reg_b_next = item.write_data;
                            flag_clr       = IFR_CB1 | IFR_CB2;
                        end
                        REG_ORA:
                        begin
                            out_reg_a_next = item.write_data;
                            flag_clr       = IFR_CA1 | IFR_CA2;
                        end
                        REG_DDRB: dir_mask_b_next = item.write_data;
                        REG_DDRA: dir_mask_a_next = item.write_data;
                        REG_T1CL, REG_T1LL:
                            timer1_reload_next = {timer1_reload_reg[15:8], item.write_data};
                        REG_T1CH:
                        begin
                            timer1_reload_next = reload_hi_written;
                            timer1_count_next  = reload_hi_written;
                            timer1_active_next = 1'b1;
                            flag_clr           = IFR_T1;
                            if (aux_control_reg[ACR_PB7_OUT])
                            begin
                                out_reg_b_next = {1'b0, out_reg_b_reg[6:0]};
                            end
                        end
                        REG_T1LH:
                        begin
                            timer1_reload_next = reload_hi_written;
                            flag_clr           = IFR_T1;
                        end
                        REG_T2CL: timer2_low_hold_next = item.write_data;
                        REG_T2CH:
                        begin
                            timer2_count_next  = {item.write_data, timer2_low_hold_reg};
                            timer2_active_next = 1'b1;
                            flag_clr           = IFR_T2;
                        end
                        REG_SR:
                        begin
                            shift_byte_next = item.write_data;
                            flag_clr        = IFR_SR;
                        end
                        REG_ACR:  aux_control_next    = item.write_data;
                        REG_PCR:  periph_control_next = item.write_data;
                        REG_IFR:  flag_clr = item.write_data[6:0];
                        REG_IER:
                        begin
                            if (item.write_data[IER_SET])
                            begin
                                irq_enables_next = irq_enables_reg | item.write_data[6:0];
                            end
                            else
                            begin
                                irq_enables_next = irq_enables_reg & ~item.write_data[6:0];
                            end
                        end
                        default:  out_reg_a_next = item.write_data;
                    endcase
                end
                ACT_TICK:
                begin
                    if (timer1_active_reg)
                    begin
                        if (timer1_count_reg == '0)
                        begin
                            flag_set = flag_set | IFR_T1;
                            if (aux_control_reg[ACR_PB7_OUT])
                            begin
                                out_reg_b_next = out_reg_b_reg ^ 8'h80;
                            end
                            if (aux_control_reg[ACR_T1_FREE])
                            begin
                                timer1_count_next = timer1_reload_reg;
                            end
                            else
                            begin
                                timer1_count_next  = TIMER_IDLE;
                                timer1_active_next = 1'b0;
                            end
                        end
                        else
                        begin
                            timer1_count_next = timer1_count_reg - 16'd1;
                        end
                    end
                    // Pulse mode holds timer 2.
                    if (timer2_active_reg && !aux_control_reg[ACR_T2_PULSE])
                    begin
                        if (timer2_count_reg == '0)
                        begin
                            flag_set           = flag_set | IFR_T2;
                            timer2_count_next  = TIMER_IDLE;
                            timer2_active_next = 1'b0;
                        end
                        else
                        begin
                            timer2_count_next = timer2_count_reg - 16'd1;
                        end
                    end
                end
                ACT_CA1:
                begin
                    if (item.pin_level != ca1_last_reg
                        && item.pin_level == periph_control_reg[PCR_CA1_POS])
                    begin
                        flag_set = IFR_CA1;
                    end
                    ca1_last_next = item.pin_level;
                end
                ACT_CB1:
                begin
                    if (item.pin_level != cb1_last_reg
                        && item.pin_level == periph_control_reg[PCR_CB1_POS])
                    begin
                        flag_set = IFR_CB1;
                    end
                    cb1_last_next = item.pin_level;
                end
                default:
                begin
                    read_byte = '0;
                end
            endcase
        end

        // No single action both clears and sets flags.
        irq_flags_next = (irq_flags_reg & ~flag_clr) | flag_set;
    end

    always_comb
    begin
        result.read_data  = read_byte;
        result.irq        = |(irq_flags_next & irq_enables_next);
        result.port_a_out = out_reg_a_next;
        result.port_a_dir = dir_mask_a_next;
        result.port_b_out = out_reg_b_next;
        result.port_b_dir = dir_mask_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg_b_reg       <= '0;
            out_reg_a_reg       <= '0;
            dir_mask_b_reg      <= '0;
            dir_mask_a_reg      <= '0;
            timer1_count_reg    <= TIMER_IDLE;
            timer1_reload_reg   <= TIMER_IDLE;
            timer2_count_reg    <= TIMER_IDLE;
            timer2_low_hold_reg <= '1;
            shift_byte_reg      <= '0;
            aux_control_reg     <= '0;
            periph_control_reg  <= '0;
            irq_flags_reg       <= '0;
            irq_enables_reg     <= '0;
            timer1_active_reg   <= 1'b0;
            timer2_active_reg   <= 1'b0;
            ca1_last_reg        <= 1'b1;
            cb1_last_reg        <= 1'b1;
        end
        else
        begin
            out_reg_b_reg       <= out_reg_b_next;
            out_reg_a_reg       <= out_reg_a_next;
            dir_mask_b_reg      <= dir_mask_b_next;
            dir_mask_a_reg      <= dir_mask_a_next;
            timer1_count_reg    <= timer1_count_next;
            timer1_reload_reg   <= timer1_reload_next;
            timer2_count_reg    <= timer2_count_next;
            timer2_low_hold_reg <= timer2_low_hold_next;
            shift_byte_reg      <= shift_byte_next;
            aux_control_reg     <= aux_control_next;
            periph_control_reg  <= periph_control_next;
            irq_flags_reg       <= irq_flags_next;
            irq_enables_reg     <= irq_enables_next;
            timer1_active_reg   <= timer1_active_next;
            timer2_active_reg   <= timer2_active_next;
            ca1_last_reg        <= ca1_last_next;
            cb1_last_reg        <= cb1_last_next;
        end
    end

    // Without an applied item no flag or counter may move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(irq_flags_reg) && $stable(timer1_count_reg)
                  && $stable(timer2_count_reg))
        else $error("state changed without an applied item");

    // One-shot timer 1 expiring parks at the idle count and stops.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_TICK && timer1_active_reg
        && timer1_count_reg == '0 && !aux_control_reg[ACR_T1_FREE]
        |=> !timer1_active_reg && timer1_count_reg == TIMER_IDLE
            && irq_flags_reg[6])
        else $error("timer 1 one-shot expiry mishandled");

    // Pulse mode freezes timer 2 on a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_TICK && aux_control_reg[ACR_T2_PULSE]
        |=> $stable(timer2_count_reg))
        else $error("timer 2 counted in pulse mode");

endmodule

`default_nettype wire

// ===== hw/rtl/versatile_interface_adapter.sv =====
// Top level of the versatile interface adapter: input register, result
// register and handshake control around via_core. Uses via_pkg and via_if.
`default_nettype none

// The adapter takes one item per clock while the sink is ready: a bus read or
// write, a timer tick, or a new CA1 or CB1 level. Each item is held in the
// input register, where via_core applies it to the registers, and its result
// then sits in the result register until the sink takes it. Both stages
// advance together, and with the sink ready a new item is accepted every
// cycle; a stalled result holds the input register and then drops ready.
// Reset is asynchronous and needs no clearing pass.
module versatile_interface_adapter (
    input  wire         clk,
    input  wire         rst_n,
    via_item_if.sink     req,
    via_result_if.source rsp
);
    import via_pkg::*;

    logic        in_valid_reg;
    via_item_t   in_item_reg;
    logic        out_valid_reg;
    via_result_t out_result_reg;

    logic        advance;
    via_result_t core_result;

    // The item in the input register is applied once the result stage frees.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    via_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.action      <= req.action;
            in_item_reg.reg_addr    <= req.reg_addr;
            in_item_reg.write_data  <= req.write_data;
            in_item_reg.pin_level   <= req.pin_level;
            in_item_reg.port_a_pins <= req.port_a_pins;
            in_item_reg.port_b_pins <= req.port_b_pins;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_result_reg.read_data;
    assign rsp.irq        = out_result_reg.irq;
    assign rsp.port_a_out = out_result_reg.port_a_out;
    assign rsp.port_a_dir = out_result_reg.port_a_dir;
    assign rsp.port_b_out = out_result_reg.port_b_out;
    assign rsp.port_b_dir = out_result_reg.port_b_dir;

    // A stalled result keeps the input stage from applying its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |-> !advance)
        else $error("item applied while result stalled");

    // A transfer into an occupied input stage always finds a result stage that moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && req.valid && req.ready |-> advance)
        else $error("input register overwritten before use");

    // Every applied item yields a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("applied item produced no result");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for versatile_interface_adapter: directed and random bus, timer and pin traffic,
// each result checked against an in-bench copy of the adapter's registers and timers.
// Depends on via_pkg, via_if and the adapter RTL.

module tb_top;

    import via_pkg::*;

    localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 10_000_000;

    logic clk;
    logic rst_n;

    via_item_if   req_ch ();
    via_result_if rsp_ch ();

    versatile_interface_adapter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the adapter's registers and timers.
    logic [7:0]  ora_r, orb_r, ddra_r, ddrb_r;
    logic [15:0] t1_count, t1_latch, t2_count;
    logic [7:0]  t2_latch_lo, sr_r, acr_r, pcr_r;
    logic [6:0]  ifr_r, ier_r;
    logic        t1_running, t2_running, ca1_prev, cb1_prev;

    via_result_t predicted_results[$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  useful_sent     = 0;
    int  results_checked = 0;
    int  t1_expiries     = 0;
    int  t2_expiries     = 0;
    int  edges_flagged   = 0;
    bit  no_idle         = 1'b0;
    bit  hold_off_req    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d results still outstanding", predicted_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pins();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)
            return 8'hFF;
        if (roll < 3)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] timer_high_byte();
        if ($urandom_range(0, 4) != 0)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] port_reg();
        case ($urandom_range(0, 4))
            0:       return REG_ORB;
            1:       return REG_ORA;
            2:       return REG_DDRB;
            3:       return REG_DDRA;
            default: return REG_ORA_NH;
        endcase
    endfunction

    function automatic via_item_t make_item(input logic [2:0] act, input logic [3:0] addr,
                                            input logic [7:0] data);
        via_item_t it;
        it.action      = act;
        it.reg_addr    = addr;
        it.write_data  = data;
        it.pin_level   = 1'($urandom_range(0, 1));
        it.port_a_pins = pick_pins();
        it.port_b_pins = pick_pins();
        return it;
    endfunction

    // Applies one item to the shadow state and returns the result the adapter should give.
    function automatic via_result_t adapter_step(input via_item_t it);
        via_result_t res;
        logic [7:0]  rd;
        logic [7:0]  pa_val;
        logic [7:0]  pb_val;
        logic [7:0]  d;
        rd = 8'h00;
        d  = it.write_data;
        pa_val = (ora_r & ddra_r) | (it.port_a_pins & ~ddra_r);
        pb_val = (orb_r & ddrb_r) | (it.port_b_pins & ~ddrb_r);
        if (acr_r[ACR_PB7_OUT])
            pb_val[7] = orb_r[7];

        case (it.action)
            ACT_READ:
            begin
                case (it.reg_addr)
                    REG_ORB:
                    begin
                        rd = pb_val;
                        ifr_r = ifr_r & ~(IFR_CB1 | IFR_CB2);
                    end
                    REG_ORA:
                    begin
                        rd = pa_val;
                        ifr_r = ifr_r & ~(IFR_CA1 | IFR_CA2);
                    end
                    REG_DDRB: rd = ddrb_r;
                    REG_DDRA: rd = ddra_r;
                    REG_T1CL:
                    begin
                        rd = t1_count[7:0];
                        ifr_r = ifr_r & ~IFR_T1;
                    end
                    REG_T1CH: rd = t1_count[15:8];
                    REG_T1LL: rd = t1_latch[7:0];
                    REG_T1LH: rd = t1_latch[15:8];
                    REG_T2CL:
                    begin
                        rd = t2_count[7:0];
                        ifr_r = ifr_r & ~IFR_T2;
                    end
                    REG_T2CH: rd = t2_count[15:8];
                    REG_SR:
                    begin
                        rd = sr_r;
                        ifr_r = ifr_r & ~IFR_SR;
                    end
                    REG_ACR:  rd = acr_r;
                    REG_PCR:  rd = pcr_r;
                    REG_IFR:  rd = {|(ifr_r & ier_r), ifr_r};
                    REG_IER:  rd = {1'b1, ier_r};
                    default:  rd = pa_val;
                endcase
            end
            ACT_WRITE:
            begin
                case (it.reg_addr)
                    REG_ORB:
                    begin
                        orb_r = d;
                        ifr_r = ifr_r & ~(IFR_CB1 | IFR_CB2);
                    end
                    REG_ORA:
                    begin
                        ora_r = d;
                        ifr_r = ifr_r & ~(IFR_CA1 | IFR_CA2);
                    end
                    REG_DDRB: ddrb_r = d;
                    REG_DDRA: ddra_r = d;
                    REG_T1CL, REG_T1LL: t1_latch[7:0] = d;
                    REG_T1CH:
                    begin
                        t1_latch[15:8] = d;
                        t1_count = t1_latch;
                        t1_running = 1'b1;
                        ifr_r = ifr_r & ~IFR_T1;
                        if (acr_r[ACR_PB7_OUT])
                            orb_r[7] = 1'b0;
                    end
                    REG_T1LH:
                    begin
                        t1_latch[15:8] = d;
                        ifr_r = ifr_r & ~IFR_T1;
                    end
                    REG_T2CL: t2_latch_lo = d;
                    REG_T2CH:
                    begin
                        t2_count = {d, t2_latch_lo};
                        t2_running = 1'b1;
                        ifr_r = ifr_r & ~IFR_T2;
                    end
                    REG_SR:
                    begin
                        sr_r = d;
                        ifr_r = ifr_r & ~IFR_SR;
                    end
                    REG_ACR: acr_r = d;
                    REG_PCR: pcr_r = d;
                    REG_IFR: ifr_r = ifr_r & ~d[6:0];
                    REG_IER:
                    begin
                        if (d[IER_SET])
                            ier_r = ier_r | d[6:0];
                        else
                            ier_r = ier_r & ~d[6:0];
                    end
                    default: ora_r = d;
                endcase
            end
            ACT_TICK:
            begin
                if (t1_running)
                begin
                    if (t1_count == 16'h0000)
                    begin
                        ifr_r = ifr_r | IFR_T1;
                        t1_expiries++;
                        if (acr_r[ACR_PB7_OUT])
                            orb_r[7] = ~orb_r[7];
                        if (acr_r[ACR_T1_FREE])
                            t1_count = t1_latch;
                        else
                        begin
                            t1_count = TIMER_IDLE;
                            t1_running = 1'b0;
                        end
                    end
                    else
                        t1_count = t1_count - 16'd1;
                end
                // Pulse-counting mode holds timer 2 still.
                if (t2_running && !acr_r[ACR_T2_PULSE])
                begin
                    if (t2_count == 16'h0000)
                    begin
                        ifr_r = ifr_r | IFR_T2;
                        t2_expiries++;
                        t2_count = TIMER_IDLE;
                        t2_running = 1'b0;
                    end
                    else
                        t2_count = t2_count - 16'd1;
                end
            end
            ACT_CA1:
            begin
                if (it.pin_level != ca1_prev && it.pin_level == pcr_r[PCR_CA1_POS])
                begin
                    ifr_r = ifr_r | IFR_CA1;
                    edges_flagged++;
                end
                ca1_prev = it.pin_level;
            end
            ACT_CB1:
            begin
                if (it.pin_level != cb1_prev && it.pin_level == pcr_r[PCR_CB1_POS])
                begin
                    ifr_r = ifr_r | IFR_CB1;
                    edges_flagged++;
                end
                cb1_prev = it.pin_level;
            end
            default:
            begin
            end
        endcase

        res.read_data  = rd;
        res.irq        = |(ifr_r & ier_r);
        res.port_a_out = ora_r;
        res.port_a_dir = ddra_r;
        res.port_b_out = orb_r;
        res.port_b_dir = ddrb_r;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("result %0d field %s: got %02h, expected %02h",
                                   results_checked, name, got, want));
    endtask

    task automatic check_result();
        via_result_t want;
        if (predicted_results.size() == 0)
        begin
            report_error("result transfer with no prediction pending");
            return;
        end
        want = predicted_results.pop_front();
        compare_field("read_data",  rsp_ch.read_data,  want.read_data);
        compare_field("irq",        {7'b0, rsp_ch.irq}, {7'b0, want.irq});
        compare_field("port_a_out", rsp_ch.port_a_out, want.port_a_out);
        compare_field("port_a_dir", rsp_ch.port_a_dir, want.port_a_dir);
        compare_field("port_b_out", rsp_ch.port_b_out, want.port_b_out);
        compare_field("port_b_dir", rsp_ch.port_b_dir, want.port_b_dir);
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result();
    end

    // Result-side ready: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                rsp_ch.ready = 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_item(input via_item_t it);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid       = 1'b1;
        req_ch.action      = it.action;
        req_ch.reg_addr    = it.reg_addr;
        req_ch.write_data  = it.write_data;
        req_ch.pin_level   = it.pin_level;
        req_ch.port_a_pins = it.port_a_pins;
        req_ch.port_b_pins = it.port_b_pins;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted_results.push_back(adapter_step(it));
        items_sent++;
        if (it.action <= ACT_CB1)
            useful_sent++;
    endtask

    task automatic send_read(input logic [3:0] addr);
        send_item(make_item(ACT_READ, addr, 8'($urandom_range(0, 255))));
    endtask

    task automatic send_write(input logic [3:0] addr, input logic [7:0] data);
        send_item(make_item(ACT_WRITE, addr, data));
    endtask

    task automatic send_tick();
        send_item(make_item(ACT_TICK, 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255))));
    endtask

    task automatic tick_burst(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 6) == 0)
                send_read(4'($urandom_range(0, 15)));
            else
                send_tick();
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_register_access();
        via_item_t it;
        send_read(REG_IER);
        send_read(REG_T1CH);
        send_item(make_item(ACT_RSVD_FIRST, 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255))));
        send_item(make_item(ACT_RSVD_LAST, 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255))));
        send_write(REG_DDRA, 8'hF0);
        send_write(REG_ORA, 8'hA5);
        it = make_item(ACT_READ, REG_ORA, 8'h00);
        it.port_a_pins = 8'h00;
        send_item(it);
        it = make_item(ACT_READ, REG_ORA_NH, 8'hFF);
        it.port_a_pins = 8'hFF;
        send_item(it);
    endtask

    task automatic test_timers();
        via_item_t it;
        // PB7 driven by timer 1, free-running with a latch of one.
        send_write(REG_ACR, 8'hC0);
        send_write(REG_T1CL, 8'h01);
        send_write(REG_T1CH, 8'h00);
        repeat (3) send_tick();
        it = make_item(ACT_READ, REG_ORB, 8'h00);
        it.port_b_pins = 8'h00;
        send_item(it);
        send_read(REG_T1CL);
    endtask

    task automatic test_pin_edges();
        via_item_t it;
        send_write(REG_IER, 8'hFF);
        it = make_item(ACT_CA1, REG_ORB, 8'h00);
        it.pin_level = 1'b0;
        send_item(it);
        send_item(it);
        send_read(REG_IFR);
        send_read(REG_ORA);
        send_write(REG_PCR, 8'h11);
        it = make_item(ACT_CB1, REG_ORA_NH, 8'hFF);
        it.pin_level = 1'b0;
        send_item(it);
        it.pin_level = 1'b1;
        send_item(it);
        send_write(REG_IFR, 8'h7F);
    endtask

    // One short, mostly well-formed sequence with random content.
    task automatic run_scenario();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 1))
                send_write(REG_ACR, 8'($urandom_range(0, 255)));
            send_write($urandom_range(0, 1) ? REG_T1LL : REG_T1CL,
                       8'($urandom_range(0, 24)));
            if ($urandom_range(0, 2) == 0)
                send_write(REG_T1LH, timer_high_byte());
            send_write(REG_T1CH, timer_high_byte());
            tick_burst($urandom_range(1, 40));
        end
        else if (pick < 45)
        begin
            if ($urandom_range(0, 3) == 0)
                send_write(REG_ACR, 8'($urandom_range(0, 255)));
            send_write(REG_T2CL, 8'($urandom_range(0, 24)));
            send_write(REG_T2CH, timer_high_byte());
            tick_burst($urandom_range(1, 40));
            send_read(REG_T2CL);
        end
        else if (pick < 60)
        begin
            n = $urandom_range(2, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                    send_write(port_reg(), 8'($urandom_range(0, 255)));
                else
                    send_read(port_reg());
            end
        end
        else if (pick < 75)
        begin
            if ($urandom_range(0, 1))
                send_write(REG_PCR, 8'($urandom_range(0, 255)));
            n = $urandom_range(2, 8);
            repeat (n)
                send_item(make_item($urandom_range(0, 1) ? ACT_CA1 : ACT_CB1,
                                    4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255))));
            send_read(REG_IFR);
            send_read($urandom_range(0, 1) ? REG_ORA : REG_ORB);
        end
        else if (pick < 88)
        begin
            send_write(REG_IER, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                send_write(REG_IFR, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                send_write(REG_SR, 8'($urandom_range(0, 255)));
            send_read($urandom_range(0, 1) ? REG_IER : REG_IFR);
            send_read(4'($urandom_range(0, 15)));
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_item(make_item(3'($urandom_range(ACT_READ, ACT_RSVD_LAST)),
                                    4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255))));
        end
    endtask

    task automatic test_random_traffic();
        int target;
        target = useful_sent + RANDOM_ITEMS;
        while (useful_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            run_scenario();
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering back-to-back transfers.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        send_write(REG_T1CL, 8'h03);
        send_write(REG_T1CH, 8'h00);
        tick_burst(40);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (2) run_scenario();
        wait_for_drain();
        repeat (2) run_scenario();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_READ;
        req_ch.reg_addr    = REG_ORB;
        req_ch.write_data  = 8'h00;
        req_ch.pin_level   = 1'b0;
        req_ch.port_a_pins = 8'hFF;
        req_ch.port_b_pins = 8'hFF;

        ora_r = 8'h00;
        orb_r = 8'h00;
        ddra_r = 8'h00;
        ddrb_r = 8'h00;
        t1_count = TIMER_IDLE;
        t1_latch = TIMER_IDLE;
        t2_count = TIMER_IDLE;
        t2_latch_lo = 8'hFF;
        sr_r = 8'h00;
        acr_r = 8'h00;
        pcr_r = 8'h00;
        ifr_r = 7'h00;
        ier_r = 7'h00;
        t1_running = 1'b0;
        t2_running = 1'b0;
        ca1_prev = 1'b1;
        cb1_prev = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_timers();
        test_pin_edges();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transfers in and %0d results out, including a %0d-cycle hold-off.",
                 items_sent, results_checked, HOLD_CYCLES);
        $display("Timer 1 expired %0d times, timer 2 %0d times; %0d pin edges raised a flag.",
                 t1_expiries, t2_expiries, edges_flagged);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
